// ----- rtl/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg: shared constants for the point to segment distance block
// Widths of the coordinate, fraction, parameter and distance datapaths, and select codes.
// ----------------------------------------------------------------------------
package psd_pkg;
  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int T_BITS         = 16;
  localparam int DIST_BITS      = 17;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam logic [1:0] SEL_START = 2'd0;
  localparam logic [1:0] SEL_END   = 2'd1;
  localparam logic [1:0] SEL_LERP  = 2'd2;
endpackage

// ----- rtl/psd_if.sv -----
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if: valid/ready channels of the distance block
// One item per accepted handshake.
// ----------------------------------------------------------------------------
interface psd_in_if #(parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF) ();
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] query_x, query_y, query_z;
  logic signed [COORD_BITS-1:0] seg_start_x, seg_start_y, seg_start_z;
  logic signed [COORD_BITS-1:0] seg_end_x, seg_end_y, seg_end_z;
  modport source (output valid, query_x, query_y, query_z, seg_start_x, seg_start_y,
                  seg_start_z, seg_end_x, seg_end_y, seg_end_z, input ready);
  modport sink (input valid, query_x, query_y, query_z, seg_start_x, seg_start_y,
                seg_start_z, seg_end_x, seg_end_y, seg_end_z, output ready);
endinterface

interface psd_out_if #(parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF) ();
  logic valid;
  logic ready;
  logic [psd_pkg::DIST_BITS-1:0] dist_res;
  logic signed [COORD_BITS-1:0] closest_x, closest_y, closest_z;
  modport source (output valid, dist_res, closest_x, closest_y, closest_z, input ready);
  modport sink (input valid, dist_res, closest_x, closest_y, closest_z, output ready);
endinterface

// ----- rtl/point_segment_distance_top.sv -----
// Stages: setup 3, T_BITS divide cells, lerp and square 3, COORD_BITS + 2 root cells,
// output register 1.
// Throughput: one item per cycle while the output is not held; each cell of the divide and root rows handles one item.
// The whole pipeline stalls as one when the output is held and its last stage is full.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// point_segment_distance_top: closest point on a 3D segment and distance
// Pipelined projection, divide row, interpolation and square root row.
// ----------------------------------------------------------------------------
module point_segment_distance_top #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  psd_in_if.sink    in_ch,
  psd_out_if.source out_ch
);
  localparam int TB = psd_pkg::T_BITS;
  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PRW = 2 * DW + 2;
  localparam int SW = 2 * CW + 4;
  localparam int RW = PRW + 1;
  localparam int NSQ = SW / 2;
  localparam int PW = 3 * CW;
  localparam int DBW = psd_pkg::DIST_BITS;

  logic en;
  logic s1_v, s2_v, s3_v, s4_v, s5_v;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: differences
  logic signed [DW-1:0] s1_d [3];
  logic signed [DW-1:0] s1_r [3];
  logic signed [CW-1:0] s1_s [3];
  logic signed [CW-1:0] s1_e [3];
  logic signed [CW-1:0] s1_q [3];
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_ch.valid;
    if (en) begin
      s1_q[0] <= in_ch.query_x; s1_q[1] <= in_ch.query_y; s1_q[2] <= in_ch.query_z;
      s1_s[0] <= in_ch.seg_start_x; s1_s[1] <= in_ch.seg_start_y;
      s1_s[2] <= in_ch.seg_start_z;
      s1_e[0] <= in_ch.seg_end_x; s1_e[1] <= in_ch.seg_end_y; s1_e[2] <= in_ch.seg_end_z;
      s1_d[0] <= DW'(in_ch.seg_end_x) - DW'(in_ch.seg_start_x);
      s1_d[1] <= DW'(in_ch.seg_end_y) - DW'(in_ch.seg_start_y);
      s1_d[2] <= DW'(in_ch.seg_end_z) - DW'(in_ch.seg_start_z);
      s1_r[0] <= DW'(in_ch.query_x) - DW'(in_ch.seg_start_x);
      s1_r[1] <= DW'(in_ch.query_y) - DW'(in_ch.seg_start_y);
      s1_r[2] <= DW'(in_ch.query_z) - DW'(in_ch.seg_start_z);
    end
  end

  // stage 2: products
  logic signed [2*DW-1:0] s2_pd [3];
  logic signed [2*DW-1:0] s2_pl [3];
  logic signed [DW-1:0]   s2_d [3];
  logic signed [CW-1:0]   s2_s [3];
  logic signed [CW-1:0]   s2_e [3];
  logic signed [CW-1:0]   s2_q [3];
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_pd[i] <= s1_r[i] * s1_d[i];
        s2_pl[i] <= s1_d[i] * s1_d[i];
      end
      s2_d <= s1_d; s2_s <= s1_s; s2_e <= s1_e; s2_q <= s1_q;
    end
  end

  // stage 3: sums and classification
  logic signed [PRW-1:0] dot, len2;
  logic [1:0] s3_sel;
  logic [RW-1:0] s3_rem, s3_den;
  logic signed [DW-1:0] s3_d [3];
  logic signed [CW-1:0] s3_s [3];
  logic signed [CW-1:0] s3_e [3];
  logic signed [CW-1:0] s3_q [3];
  assign dot = PRW'(s2_pd[0]) + PRW'(s2_pd[1]) + PRW'(s2_pd[2]);
  assign len2 = PRW'(s2_pl[0]) + PRW'(s2_pl[1]) + PRW'(s2_pl[2]);
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
    if (en) begin
      if (len2 == '0 || dot <= 0) s3_sel <= psd_pkg::SEL_START;
      else if (dot >= len2) s3_sel <= psd_pkg::SEL_END;
      else s3_sel <= psd_pkg::SEL_LERP;
      s3_rem <= RW'(unsigned'(dot));
      s3_den <= RW'(unsigned'(len2));
      s3_d <= s2_d; s3_s <= s2_s; s3_e <= s2_e; s3_q <= s2_q;
    end
  end

  // divide row: payload is sel, d, s, e, q
  localparam int DPW = 2 + 3 * DW + 9 * CW;
  logic          dv   [TB+1];
  logic [RW-1:0] drem [TB+1];
  logic [RW-1:0] dden [TB+1];
  logic [TB-1:0] dt   [TB+1];
  logic [DPW-1:0] dpay [TB+1];
  assign dv[0] = s3_v;
  assign drem[0] = s3_rem;
  assign dden[0] = s3_den;
  assign dt[0] = '0;
  assign dpay[0] = {s3_sel, s3_d[0], s3_d[1], s3_d[2], s3_s[0], s3_s[1], s3_s[2],
                    s3_e[0], s3_e[1], s3_e[2], s3_q[0], s3_q[1], s3_q[2]};
  for (genvar g = 0; g < TB; g++) begin : g_div
    psd_div_cell #(.RW(RW), .PW(DPW)) u_cell (
      .clk(clk), .rst(rst), .en(en), .in_v(dv[g]), .in_rem(drem[g]), .in_den(dden[g]),
      .in_t(dt[g]), .in_pay(dpay[g]), .out_v(dv[g+1]), .out_rem(drem[g+1]),
      .out_den(dden[g+1]), .out_t(dt[g+1]), .out_pay(dpay[g+1])
    );
  end

  logic [1:0] u_sel;
  logic signed [DW-1:0] u_d [3];
  logic signed [CW-1:0] u_s [3];
  logic signed [CW-1:0] u_e [3];
  logic signed [CW-1:0] u_q [3];
  assign {u_sel, u_d[0], u_d[1], u_d[2], u_s[0], u_s[1], u_s[2],
          u_e[0], u_e[1], u_e[2], u_q[0], u_q[1], u_q[2]} = dpay[TB];
  logic [TB-1:0] u_t;
  assign u_t = dt[TB];

  // stage 4: interpolation product
  logic signed [DW+TB:0] s4_p [3];
  logic [1:0] s4_sel;
  logic signed [CW-1:0] s4_s [3];
  logic signed [CW-1:0] s4_e [3];
  logic signed [CW-1:0] s4_q [3];
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= dv[TB];
    if (en) begin
      for (int i = 0; i < 3; i++)
        s4_p[i] <= (DW+TB+1)'(u_d[i]) * $signed({1'b0, u_t});
      s4_sel <= u_sel; s4_s <= u_s; s4_e <= u_e; s4_q <= u_q;
    end
  end

  // stage 5: closest point and offset to query
  logic signed [CW-1:0] c [3];
  logic signed [DW+TB:0] rnd [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (s4_p[i] + (DW+TB+1)'(1 << (TB-1))) >>> TB;
      case (s4_sel)
        psd_pkg::SEL_START: c[i] = s4_s[i];
        psd_pkg::SEL_END: c[i] = s4_e[i];
        default: c[i] = CW'(s4_s[i] + CW'(rnd[i]));
      endcase
    end
  end
  logic signed [CW-1:0] s5_c [3];
  logic signed [DW-1:0] s5_r [3];
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_c[i] <= c[i];
        s5_r[i] <= DW'(c[i]) - DW'(s4_q[i]);
      end
    end
  end

  // stage 6: squared distance
  logic s6_v;
  logic [SW-1:0] s6_sq;
  logic signed [CW-1:0] s6_c [3];
  logic signed [2*DW-1:0] sqr [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      sqr[i] = s5_r[i] * s5_r[i];
  end
  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= s5_v;
    if (en) begin
      s6_sq <= SW'(sqr[0]) + SW'(sqr[1]) + SW'(sqr[2]);
      s6_c <= s5_c;
    end
  end

  // root row
  logic          qv   [NSQ+1];
  logic [SW-1:0] qval [NSQ+1];
  logic [SW-1:0] qres [NSQ+1];
  logic [PW-1:0] qpay [NSQ+1];
  assign qv[0] = s6_v;
  assign qval[0] = s6_sq >> (2 * FRAC_BITS);
  assign qres[0] = '0;
  assign qpay[0] = {s6_c[0], s6_c[1], s6_c[2]};
  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    psd_sqrt_cell #(.SW(SW), .BITPOS(2*(NSQ-1-g)), .PW(PW)) u_cell (
      .clk(clk), .rst(rst), .en(en), .in_v(qv[g]), .in_val(qval[g]), .in_res(qres[g]),
      .in_pay(qpay[g]), .out_v(qv[g+1]), .out_val(qval[g+1]), .out_res(qres[g+1]),
      .out_pay(qpay[g+1])
    );
  end

  // output register
  logic [SW-1:0] root;
  assign root = qres[NSQ];
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= qv[NSQ];
    if (en) begin
      out_ch.dist_res <= (root > SW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                                                        : root[DBW-1:0];
      out_ch.closest_x <= qpay[NSQ][PW-1 -: CW];
      out_ch.closest_y <= qpay[NSQ][PW-CW-1 -: CW];
      out_ch.closest_z <= qpay[NSQ][PW-2*CW-1 -: CW];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.dist_res))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready) else $error("stalled with empty output");
  a_sel: assert property (@(posedge clk) disable iff (rst)
    s4_v |-> (s4_sel == psd_pkg::SEL_START || s4_sel == psd_pkg::SEL_END ||
              s4_sel == psd_pkg::SEL_LERP)) else $error("bad select");
endmodule

// ----- rtl/psd_div_cell.sv -----
// ----------------------------------------------------------------------------
// psd_div_cell: one restoring division step, one quotient bit
// Carries the item's payload on to the next cell each cycle it advances.
// ----------------------------------------------------------------------------
module psd_div_cell #(
  parameter int RW = 64,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [RW-1:0] in_rem,
  input  logic [RW-1:0] in_den,
  input  logic [psd_pkg::T_BITS-1:0] in_t,
  input  logic [PW-1:0] in_pay,
  output logic          out_v,
  output logic [RW-1:0] out_rem,
  output logic [RW-1:0] out_den,
  output logic [psd_pkg::T_BITS-1:0] out_t,
  output logic [PW-1:0] out_pay
);
  logic [RW:0] sh;
  logic        ge;
  assign sh = {in_rem, 1'b0};
  assign ge = sh >= {1'b0, in_den};
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
    if (en) begin
      out_rem <= ge ? RW'(sh - {1'b0, in_den}) : sh[RW-1:0];
      out_den <= in_den;
      out_t   <= {in_t[psd_pkg::T_BITS-2:0], ge};
      out_pay <= in_pay;
    end
  end
endmodule

// ----- rtl/psd_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// psd_sqrt_cell: one digit step of the integer square root
// Handles one bit pair of the radicand per cell, passing payload along.
// ----------------------------------------------------------------------------
module psd_sqrt_cell #(
  parameter int SW = 64,
  parameter int BITPOS = 0,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [SW-1:0] in_val,
  input  logic [SW-1:0] in_res,
  input  logic [PW-1:0] in_pay,
  output logic          out_v,
  output logic [SW-1:0] out_val,
  output logic [SW-1:0] out_res,
  output logic [PW-1:0] out_pay
);
  localparam logic [SW-1:0] BIT = SW'(1) << BITPOS;
  logic [SW-1:0] trial;
  assign trial = in_res + BIT;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
    if (en) begin
      out_pay <= in_pay;
      if (in_val >= trial) begin
        out_val <= in_val - trial;
        out_res <= (in_res >> 1) + BIT;
      end else begin
        out_val <= in_val;
        out_res <= in_res >> 1;
      end
    end
  end
endmodule
